// ===== hw/rtl/frame_brightness_adjust_core_assert.svh =====
// Assertion macros shared by the frame brightness RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef FRAME_BRIGHTNESS_ADJUST_CORE_ASSERT_SVH
`define FRAME_BRIGHTNESS_ADJUST_CORE_ASSERT_SVH

// Overlapping implication, checked outside reset.
`define FBADJ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbadj: assertion failed");

// Next-cycle implication, checked outside reset.
`define FBADJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbadj: assertion failed");

`endif

// ===== hw/rtl/fbadj_pkg.sv =====
// Shared types, constants and helper functions of the frame brightness block.
// No dependencies; imported by fbadj_div and frame_brightness_adjust_core.
package fbadj_pkg;

  localparam longint unsigned MAX_SAMPLES = 1048576;
  localparam int SAMPLE_W = 8;
  localparam int MEAN_W   = 8;
  localparam int COUNT_W  = $clog2(MAX_SAMPLES + 64'd1);
  localparam int SUM_W    = $clog2(MAX_SAMPLES * 64'((2 ** SAMPLE_W) - 1) + 64'd1);
  localparam int ITER_W   = $clog2(MEAN_W);

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH    = 2'd2;

  localparam logic [7:0] TARGET_RESET    = 8'd128;
  localparam logic [7:0] BAND_LOW_RESET  = 8'd126;
  localparam logic [7:0] BAND_HIGH_RESET = 8'd130;

  // floor(x / 3) == (x * 171) >> 9 for 0 <= x <= 255
  localparam logic [15:0] RECIP3       = 16'd171;
  localparam int          RECIP3_SHIFT = 9;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_level;
    logic signed [7:0] brightness_step;
    logic              needs_adjust;
  } out_item_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // (diff / 3) truncated toward zero, diff in -255..255
  function automatic logic signed [7:0] fbadj_step(input logic signed [8:0] diff);
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [7:0]  q;
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
    prod = {8'd0, mag} * RECIP3;
    q    = {1'b0, prod[15:RECIP3_SHIFT]};
    return diff[8] ? 8'(-q) : q;
  endfunction

endpackage

// ===== hw/rtl/fbadj_div.sv =====
// Bit-serial restoring divider: frame sum over sample count, one quotient bit a cycle.
// Depends on fbadj_pkg and frame_brightness_adjust_core_assert.svh.
`include "frame_brightness_adjust_core_assert.svh"

module fbadj_div
  import fbadj_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  div_ctrl_t          ctrl,
  output div_stat_t          stat,
  input  logic [SUM_W-1:0]   num,
  input  logic [COUNT_W-1:0] den,
  output logic [MEAN_W-1:0]  quo
);

  localparam int DEN_W = COUNT_W + MEAN_W - 1;
  localparam int CMP_W = (SUM_W > DEN_W) ? SUM_W : DEN_W;

  div_state_t        state, state_next;
  logic [SUM_W-1:0]  rem;
  logic [DEN_W-1:0]  den_sh;
  logic [ITER_W-1:0] iter;
  logic [CMP_W-1:0]  rem_ext, den_ext, diff;
  logic              fits;

  assign rem_ext = CMP_W'(rem);
  assign den_ext = CMP_W'(den_sh);
  assign fits    = rem_ext >= den_ext;
  assign diff    = rem_ext - den_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat.busy  = 1'b1;
    stat.done  = 1'b0;
    unique case (state)
      DIV_IDLE: begin
        stat.busy = 1'b0;
        if (ctrl.start) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (iter == '0) begin
          state_next = DIV_HOLD;
        end
      end
      DIV_HOLD: begin
        stat.done = 1'b1;
        if (ctrl.take) begin
          state_next = DIV_IDLE;
        end
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && ctrl.start) begin
      rem    <= num;
      den_sh <= {den, {(MEAN_W - 1){1'b0}}};
      iter   <= ITER_W'(MEAN_W - 1);
      quo    <= '0;
    end else if (state == DIV_RUN) begin
      if (fits) begin
        rem <= SUM_W'(diff);
      end
      quo    <= {quo[MEAN_W-2:0], fits};
      den_sh <= den_sh >> 1;
      iter   <= iter - ITER_W'(1);
    end
  end

  `FBADJ_ASSERT_NOW(a_start_idle, ctrl.start, state == DIV_IDLE)
  `FBADJ_ASSERT_NEXT(a_run_ends, state == DIV_RUN && iter == '0, state == DIV_HOLD)
  `FBADJ_ASSERT_NEXT(a_hold_stable, state == DIV_HOLD && !ctrl.take, $stable(quo) && stat.done)

endmodule

// ===== hw/rtl/frame_brightness_adjust_core.sv =====
// Frame brightness adjust: the per-frame mean level, a brightness step toward a target
// and an out-of-band flag, from a stream of 8-bit samples. Takes one sample a cycle while
// a frame streams in. After the transfer of a last sample, in_stall is held through eight
// iterations of the shared compare/subtract unit in fbadj_div, one bit of the mean each,
// and through the move of the result into the output register, held off longer while
// that register is still waiting on out_stall. Samples past MAX_SAMPLES in a frame are
// dropped from the sum and count; the result still follows the last sample.
// Depends on fbadj_pkg, fbadj_div and frame_brightness_adjust_core_assert.svh.
`include "frame_brightness_adjust_core_assert.svh"

module frame_brightness_adjust_core
  import fbadj_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  logic [7:0]         target_level, band_low, band_high;
  logic [SUM_W-1:0]   byte_sum, sum_add;
  logic [COUNT_W-1:0] byte_count, count_add;
  logic               room, in_xfer;
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [MEAN_W-1:0]  mean;
  logic signed [8:0]  level_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TARGET_RESET;
      band_low     <= BAND_LOW_RESET;
      band_high    <= BAND_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_LEVEL: target_level <= cfg_data;
        CFG_BAND_LOW:     band_low     <= cfg_data;
        CFG_BAND_HIGH:    band_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = div_stat.busy;
  assign in_xfer   = in_valid && !in_stall;
  assign room      = byte_count < COUNT_W'(MAX_SAMPLES);
  assign sum_add   = room ? byte_sum + SUM_W'(in_data.sample) : byte_sum;
  assign count_add = room ? byte_count + COUNT_W'(1) : byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_sum   <= '0;
      byte_count <= '0;
    end else if (in_xfer) begin
      if (in_data.last_sample) begin
        byte_sum   <= '0;
        byte_count <= '0;
      end else begin
        byte_sum   <= sum_add;
        byte_count <= count_add;
      end
    end
  end

  assign div_ctrl.start = in_xfer && in_data.last_sample;
  assign div_ctrl.take  = div_stat.done && (!out_valid || !out_stall);

  fbadj_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat),
    .num  (sum_add),
    .den  (count_add),
    .quo  (mean)
  );

  assign level_diff = $signed({1'b0, target_level}) - $signed({1'b0, mean});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_ctrl.take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ctrl.take) begin
      out_data.mean_level      <= mean;
      out_data.brightness_step <= fbadj_step(level_diff);
      out_data.needs_adjust    <= (mean < band_low) || (mean > band_high);
    end
  end

  `FBADJ_ASSERT_NOW(a_count_bound, 1'b1, byte_count <= COUNT_W'(MAX_SAMPLES))
  `FBADJ_ASSERT_NEXT(a_take_loads, div_ctrl.take, out_valid && !div_stat.busy)
  `FBADJ_ASSERT_NEXT(a_last_clears, div_ctrl.start, byte_count == '0 && in_stall)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for frame_brightness_adjust_core: frames of 8-bit samples in,
// per-frame mean, brightness step and out-of-band flag out, checked against a local model.
// Depends on fbadj_pkg and the RTL of frame_brightness_adjust_core.
`timescale 1ns / 100ps

module tb;
  import fbadj_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 150;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  in_item_t  pending_samples[$];
  out_item_t expected_stats[$];

  logic [SUM_W-1:0]   frame_sum = '0;
  logic [COUNT_W-1:0] frame_count = '0;
  logic [7:0]         level_target = TARGET_RESET;
  logic [7:0]         band_lo = BAND_LOW_RESET;
  logic [7:0]         band_hi = BAND_HIGH_RESET;

  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic        hold_request = 1'b0;
  logic        hold_served = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  frame_brightness_adjust_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sample driver: bursts with gaps, payload held while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid)
        void'(pending_samples.pop_front());
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_samples[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall pattern plus one long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_left   <= 0;
      hold_served <= 1'b0;
      mode_left   <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= LONG_HOLD;
      hold_served <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
        mode_left  <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  task automatic predict_frame_stats(input in_item_t s);
    logic [SUM_W-1:0] mean_full;
    int               diff;
    out_item_t        stats;
    if (frame_count < MAX_SAMPLES) begin
      frame_sum   = frame_sum + s.sample;
      frame_count = frame_count + 1'b1;
    end
    if (s.last_sample) begin
      mean_full = (frame_count != 0) ? frame_sum / frame_count : '0;
      if (mean_full > 255)
        mean_full = 255;
      diff = int'(level_target) - int'(mean_full);
      stats.mean_level      = mean_full[7:0];
      stats.brightness_step = 8'(diff / 3);
      stats.needs_adjust    = (mean_full < band_lo) || (mean_full > band_hi);
      expected_stats.push_back(stats);
      frame_sum   = '0;
      frame_count = '0;
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 30)
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        fail_count++;
        if (fail_count <= 30)
          $display("%0t: unexpected transfer, expected none actual mean %0d step %0d flag %0d",
                   $time, out_data.mean_level, $signed(out_data.brightness_step),
                   out_data.needs_adjust);
      end else begin
        check_field("mean_level", expected_stats[0].mean_level, out_data.mean_level);
        check_field("brightness_step", $signed(expected_stats[0].brightness_step),
                    $signed(out_data.brightness_step));
        check_field("needs_adjust", expected_stats[0].needs_adjust, out_data.needs_adjust);
        void'(expected_stats.pop_front());
      end
    end
    if (!rst && in_valid && !in_stall)
      predict_frame_stats(in_data);
  end

  task automatic push_sample(input logic [7:0] value, input logic last);
    in_item_t s;
    s.sample      = value;
    s.last_sample = last;
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_TARGET_LEVEL: level_target = value;
      CFG_BAND_LOW:     band_lo = value;
      CFG_BAND_HIGH:    band_hi = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_stats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Frames around a random level with a random spread, mostly short.
  task automatic queue_random_frames(input int n_items);
    int queued;
    int len;
    int center;
    int spread;
    int lo;
    int hi;
    queued = 0;
    while (queued < n_items) begin
      len    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      center = $urandom_range(0, 255);
      spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 20);
      lo     = (center - spread < 0) ? 0 : center - spread;
      hi     = (center + spread > 255) ? 255 : center + spread;
      for (int i = 0; i < len; i++)
        push_sample(8'($urandom_range(lo, hi)), i == len - 1);
      queued += len;
    end
  endtask

  task automatic random_config();
    logic [7:0] a;
    logic [7:0] b;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    write_reg(CFG_TARGET_LEVEL, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0 || a <= b) begin
      write_reg(CFG_BAND_LOW, a);
      write_reg(CFG_BAND_HIGH, b);
    end else begin
      write_reg(CFG_BAND_LOW, b);
      write_reg(CFG_BAND_HIGH, a);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: band edges, step rounding, truncated mean.
    push_sample(8'd0, 1'b1);
    push_sample(8'd255, 1'b1);
    push_sample(8'd126, 1'b1);
    push_sample(8'd130, 1'b1);
    push_sample(8'd125, 1'b1);
    push_sample(8'd131, 1'b1);
    push_sample(8'd129, 1'b1);
    push_sample(8'd124, 1'b1);
    push_sample(8'd132, 1'b1);
    push_sample(8'd255, 1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd254, 1'b1);
    push_sample(8'd0, 1'b0);
    push_sample(8'd1, 1'b1);
    push_sample(8'd3, 1'b0);
    push_sample(8'd4, 1'b0);
    push_sample(8'd4, 1'b1);
    settle();

    // Extremes: inverted band, step limits, out-of-range index ignored.
    write_reg(CFG_TARGET_LEVEL, 8'd0);
    write_reg(CFG_BAND_LOW, 8'd255);
    write_reg(CFG_BAND_HIGH, 8'd0);
    write_reg(CFG_UNUSED, 8'hA5);
    push_sample(8'd255, 1'b1);
    push_sample(8'd0, 1'b1);
    settle();
    write_reg(CFG_TARGET_LEVEL, 8'd255);
    write_reg(CFG_BAND_LOW, 8'd0);
    write_reg(CFG_BAND_HIGH, 8'd255);
    push_sample(8'd0, 1'b1);
    push_sample(8'd255, 1'b1);
    settle();

    // Long receiver hold while frames keep coming.
    random_config();
    hold_request <= 1'b1;
    queue_random_frames(RANDOM_ITEMS);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_TARGET_LEVEL, 8'd0);
          write_reg(CFG_BAND_LOW, 8'd0);
          write_reg(CFG_BAND_HIGH, 8'd255);
        end
        1: begin
          write_reg(CFG_TARGET_LEVEL, 8'd255);
          write_reg(CFG_BAND_LOW, 8'd255);
          write_reg(CFG_BAND_HIGH, 8'd255);
          write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        end
        default: random_config();
      endcase
      queue_random_frames(RANDOM_ITEMS);
      settle();
    end

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
